@@ hdl/rtcep_pkg.sv @@
// Shared types, register indexes and calendar tables for the RTC-to-epoch block.
// No dependencies.
package rtcep_pkg;

  localparam logic [7:0] CFG_BINARY_MODE  = 8'd0;
  localparam logic [7:0] CFG_HOUR_24_MODE = 8'd1;

  // Days from 1970-01-01 to 2000-01-01, before leap days are added.
  localparam logic [15:0] DAYS_1970_TO_2000 = 16'd10950;
  localparam logic [31:0] SECS_PER_DAY      = 32'd86400;
  localparam logic [31:0] EPOCH_MAX         = 32'd4102444799;

  typedef struct packed {
    logic [15:0] days;  // days since 1970-01-01
    logic [16:0] sod;   // seconds of the day
    logic        bad;   // some decoded field out of range
  } rtcep_calc_t;

  function automatic logic [7:0] bcd8(input logic [7:0] b);
    return {4'b0000, b[3:0]} + {4'b0000, b[7:4]} * 8'd10;
  endfunction

  // Month length in a common year; month codes outside 1..12 never reach use.
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before mon, common year.
  function automatic logic [8:0] days_before(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/rtcep_calc.sv @@
// Decode and range check of one RTC snapshot; gives day count and seconds of day.
// Depends on rtcep_pkg.
module rtcep_calc (
  input  logic [7:0]           raw_seconds,
  input  logic [7:0]           raw_minutes,
  input  logic [7:0]           raw_hours,
  input  logic [7:0]           raw_day,
  input  logic [7:0]           raw_month,
  input  logic [7:0]           raw_year,
  input  logic                 binary_mode,
  input  logic                 hour_24_mode,
  output rtcep_pkg::rtcep_calc_t calc
);
  import rtcep_pkg::*;

  logic [7:0]  sec, mins, hr_d, hr, day, mon, yr;
  logic [6:0]  h7;
  logic [7:0]  h12;
  logic        bad12, bad_basic, leap, bad_day;
  logic [4:0]  lim;
  logic [8:0]  doy;
  logic [7:0]  yr_adj;

  always_comb begin
    if (binary_mode) begin
      sec  = raw_seconds;
      mins = raw_minutes;
      hr_d = raw_hours;
      day  = raw_day;
      mon  = raw_month;
      yr   = raw_year;
    end else begin
      sec  = bcd8(raw_seconds);
      mins = bcd8(raw_minutes);
      // bit 7 stays apart from the tens digit
      hr_d = ({4'b0000, raw_hours[3:0]} + {5'b00000, raw_hours[6:4]} * 8'd10)
             | {raw_hours[7], 7'b0};
      day  = bcd8(raw_day);
      mon  = bcd8(raw_month);
      yr   = bcd8(raw_year);
    end
  end

  // 12-hour fold: 12 AM -> 0, 12 PM -> 12
  always_comb begin
    h7    = hr_d[6:0];
    bad12 = (h7 < 7'd1) || (h7 > 7'd12);
    h12   = (h7 == 7'd12) ? 8'd0 : {1'b0, h7};
    if (hr_d[7]) h12 = h12 + 8'd12;
    hr    = hour_24_mode ? hr_d : h12;
  end

  always_comb begin
    bad_basic = (sec > 8'd59) || (mins > 8'd59) || (hr > 8'd23) || (yr > 8'd99)
                || (mon < 8'd1) || (mon > 8'd12) || (!hour_24_mode && bad12);
    leap      = (yr[1:0] == 2'b00);
    lim       = (mon[3:0] == 4'd2 && leap) ? 5'd29 : month_len(mon[3:0]);
    bad_day   = (day < 8'd1) || (day > {3'b000, lim});
    doy       = 9'(day - 8'd1) + days_before(mon[3:0])
                + {8'b0, (leap && mon[3:0] > 4'd2)};
    yr_adj    = 8'(yr + 8'd31);
  end

  // Leap days since 1970 reduce to (yr + 31) / 4 over 2000..2099.
  assign calc.days = 16'({8'b0, yr} * 16'd365) + DAYS_1970_TO_2000
                     + {10'b0, yr_adj[7:2]} + {7'b0, doy};
  assign calc.sod  = {9'b0, sec} + 17'({9'b0, mins} * 17'd60)
                     + 17'({9'b0, hr} * 17'd3600);
  assign calc.bad  = bad_basic || bad_day;

endmodule

@@ hdl/rtc_fields_to_epoch_seconds_top.sv @@
// Top level: RTC field snapshot to seconds since 1970, two register stages.
// Depends on rtcep_pkg and rtcep_calc.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | in_raw_seconds .. in_raw_year           | start && !busy
//  result  | out_epoch_seconds, out_fields_invalid   | out_valid, one cycle
//  config  | cfg_index, cfg_data                     | cfg_valid && cfg_ready
//
// One snapshot per cycle; busy and cfg_ready are constant (never stalls).
// Each snapshot passes the input register, then the result register.
// Decode, day count and the multiply by 86400 between the two set the cycle time.
// rst_n clears valid flags and resets config (binary_mode 0, hour_24_mode 1).
// The receiver cannot stall; a result is shown for exactly one cycle.
module rtc_fields_to_epoch_seconds_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_raw_seconds,
  input  logic [7:0]  in_raw_minutes,
  input  logic [7:0]  in_raw_hours,
  input  logic [7:0]  in_raw_day,
  input  logic [7:0]  in_raw_month,
  input  logic [7:0]  in_raw_year,
  output logic        out_valid,
  output logic [31:0] out_epoch_seconds,
  output logic        out_fields_invalid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import rtcep_pkg::*;

  logic        binary_mode_r, hour_24_mode_r;
  logic        in_vld_r, out_vld_r;
  logic [7:0]  sec_r, min_r, hr_r, day_r, mon_r, yr_r;
  rtcep_calc_t calc;
  logic [31:0] epoch_nxt, epoch_r;
  logic        inv_r;
  logic        in_xfer;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_xfer   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r  <= 1'b0;
      hour_24_mode_r <= 1'b1;
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BINARY_MODE:  binary_mode_r  <= cfg_data[0];
          CFG_HOUR_24_MODE: hour_24_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      in_vld_r  <= in_xfer;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sec_r <= in_raw_seconds;
      min_r <= in_raw_minutes;
      hr_r  <= in_raw_hours;
      day_r <= in_raw_day;
      mon_r <= in_raw_month;
      yr_r  <= in_raw_year;
    end
    epoch_r <= epoch_nxt;
    inv_r   <= calc.bad;
  end

  rtcep_calc u_calc (
    .raw_seconds  (sec_r),
    .raw_minutes  (min_r),
    .raw_hours    (hr_r),
    .raw_day      (day_r),
    .raw_month    (mon_r),
    .raw_year     (yr_r),
    .binary_mode  (binary_mode_r),
    .hour_24_mode (hour_24_mode_r),
    .calc         (calc)
  );

  assign epoch_nxt = calc.bad ? 32'd0
                   : 32'({16'b0, calc.days} * SECS_PER_DAY) + {15'b0, calc.sod};

  assign out_valid          = out_vld_r;
  assign out_epoch_seconds  = epoch_r;
  assign out_fields_invalid = inv_r;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##2 out_valid)
    else $error("accepted snapshot did not produce a result two cycles later");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld_r))
    else $error("result strobe without a computed item behind it");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fields_invalid |-> out_epoch_seconds == 32'd0)
    else $error("invalid snapshot gave a nonzero epoch");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fields_invalid |-> out_epoch_seconds <= EPOCH_MAX)
    else $error("epoch seconds beyond year 2099");
`endif

endmodule
